// ----- hw/rtl/bff_pkg.sv -----
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types, codes and helpers of the brush fill framebuffer unit.
// ----------------------------------------------------------------------------
package bff_pkg;

  // Command kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_DISC   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int unsigned CfgW      = 9;
  localparam int unsigned CoordW    = 11;
  localparam int unsigned BrushW    = 7;
  localparam int unsigned ChanW     = 16;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned CountW    = 13;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 48;
  localparam logic [CfgW-1:0] FrameReset = 9'd256;

  // Cycles between the last pixel issue and a final result
  localparam int unsigned DrainCycles = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;    // write zero at the clear address and advance it
    logic load;      // capture a new command
    logic issue;     // current pixel offset is valid, advance offsets
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // clear address is at the last entry
    logic s_zero;    // brush has no pixels
    logic last;      // current offset is the last one of the brush
  } dp_status_t;

  // Clamp a signed Q3.12 channel to 0..1 and scale to a byte (truncating)
  function automatic logic [7:0] chan_byte(input logic signed [ChanW-1:0] c);
    logic [12:0] cl;
    logic [20:0] prod;
    if (c[ChanW-1]) begin
      cl = 13'd0;
    end else if (c > 16'sd4096) begin
      cl = 13'd4096;
    end else begin
      cl = c[12:0];
    end
    prod = ({8'd0, cl} << 8) - {8'd0, cl};
    return prod[19:12];
  endfunction

endpackage

// ----- hw/rtl/bff_ram.sv -----
// ----------------------------------------------------------------------------
// bff_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bff_ctrl.sv -----
// ----------------------------------------------------------------------------
// bff_ctrl
// Command sequencer: clear pass, command capture, pixel issue, drain, result.
// ----------------------------------------------------------------------------
module bff_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  m_ready_i,
  input  bff_pkg::dp_status_t   status_i,
  output bff_pkg::ctrl_cmd_t    cmd_o,
  output logic                  s_ready_o,
  output logic                  m_valid_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_START  = 6'b000100,
    ST_RUN    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } ctrl_state_e;

  localparam logic [1:0] DrainLast = 2'(bff_pkg::DrainCycles - 1);

  ctrl_state_e state_q, state_d;
  logic [1:0]  drain_q, drain_d;
  logic        m_valid_q, m_valid_d;
  logic        slot_free;

  assign slot_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        drain_d = '0;
        state_d = status_i.s_zero ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        drain_d     = '0;
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DrainLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      drain_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      drain_q   <= drain_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

// ----- hw/rtl/bff_dp.sv -----
// ----------------------------------------------------------------------------
// bff_dp
// Datapath: command registers, brush offset counters, pixel pipeline with
// clipping and disc test, framebuffer RAM, result and output registers.
// ----------------------------------------------------------------------------
module bff_dp #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_BRUSH  = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [0:0]                            cfg_index_i,
  input  logic [bff_pkg::CfgW-1:0]              cfg_data_i,
  input  logic [1:0]                            kind_i,
  input  logic signed [bff_pkg::CoordW-1:0]     x_start_i,
  input  logic signed [bff_pkg::CoordW-1:0]     y_start_i,
  input  logic [bff_pkg::BrushW-1:0]            brush_side_i,
  input  logic signed [bff_pkg::ChanW-1:0]      color_red_i,
  input  logic signed [bff_pkg::ChanW-1:0]      color_green_i,
  input  logic signed [bff_pkg::ChanW-1:0]      color_blue_i,
  input  logic signed [bff_pkg::ChanW-1:0]      color_alpha_i,
  input  bff_pkg::ctrl_cmd_t                    cmd_i,
  output bff_pkg::dp_status_t                   status_o,
  output logic [bff_pkg::OutDataW-1:0]          out_data_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW    = $clog2(MAX_BRUSH + 1);
  localparam int unsigned XW    = ((bff_pkg::CoordW > SW + 1) ? bff_pkg::CoordW : SW + 1) + 1;
  localparam int unsigned DW    = SW + 2;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned RW    = PW + 1;
  localparam int unsigned CW    = bff_pkg::CfgW;
  localparam int unsigned LW    = 2 * CW + 1;

  // Configuration
  logic [CW-1:0] width_q, height_q;
  logic [CW-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bff_pkg::FrameReset;
      height_q <= bff_pkg::FrameReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bff_pkg::REG_FRAME_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == bff_pkg::REG_FRAME_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign eff_w = (int'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : width_q;
  assign eff_h = (int'(height_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : height_q;

  // Command registers
  bff_pkg::kind_e                      kind_q;
  logic signed [bff_pkg::CoordW-1:0]   x0_q, y0_q;
  logic [SW-1:0]                       s_q, s_sat;
  logic [bff_pkg::PixelW-1:0]          pix_q;
  logic [RW-1:0]                       r4_q;
  logic [SW-1:0]                       s_even;

  assign s_sat = (int'(brush_side_i) > MAX_BRUSH) ? SW'(MAX_BRUSH) : SW'(brush_side_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= bff_pkg::kind_e'(kind_i);
      x0_q   <= x_start_i;
      y0_q   <= y_start_i;
      // single-pixel commands walk a one-pixel brush
      if (kind_i == bff_pkg::KIND_SET || kind_i == bff_pkg::KIND_READ) begin
        s_q <= SW'(1);
      end else begin
        s_q <= s_sat;
      end
      pix_q <= {bff_pkg::chan_byte(color_alpha_i), bff_pkg::chan_byte(color_red_i),
                bff_pkg::chan_byte(color_green_i), bff_pkg::chan_byte(color_blue_i)};
    end
    // (2*floor(s/2))^2, registered from the latched brush side
    r4_q <= RW'(s_even) * RW'(s_even);
  end

  assign s_even = s_q & ~SW'(1);

  // Brush offset counters
  logic [SW-1:0] i_q, j_q;
  logic          j_last, i_last;

  assign j_last = (j_q == s_q - SW'(1));
  assign i_last = (i_q == s_q - SW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.load) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.issue) begin
      if (j_last) begin
        j_q <= '0;
        i_q <= i_q + SW'(1);
      end else begin
        j_q <= j_q + SW'(1);
      end
    end
  end

  assign status_o.last   = j_last && i_last;
  assign status_o.s_zero = (s_q == '0);

  // Stage A: coordinates, clipping, disc offsets
  logic signed [XW-1:0] x_s, y_s;
  logic signed [DW-1:0] di, dj;
  logic                 in_frame;

  assign x_s = XW'(x0_q) + XW'($signed({1'b0, j_q}));
  assign y_s = XW'(y0_q) + XW'($signed({1'b0, i_q}));
  assign di  = $signed({1'b0, i_q, 1'b0}) - $signed({2'b00, s_q}) + DW'(1);
  assign dj  = $signed({1'b0, j_q, 1'b0}) - $signed({2'b00, s_q}) + DW'(1);
  assign in_frame = !x_s[XW-1] && !y_s[XW-1] &&
                    ($unsigned(x_s) < XW'(eff_w)) && ($unsigned(y_s) < XW'(eff_h));

  logic          b_valid_q;
  logic          b_in_q;
  logic [CW-1:0] b_x_q, b_y_q;
  logic [PW-1:0] b_di_sq_q, b_dj_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    b_in_q    <= in_frame;
    b_x_q     <= x_s[CW-1:0];
    b_y_q     <= y_s[CW-1:0];
    b_di_sq_q <= PW'($unsigned(PW'(di) * PW'(di)));
    b_dj_sq_q <= PW'($unsigned(PW'(dj) * PW'(dj)));
  end

  // Stage B: disc test and linear address
  logic [RW-1:0] off_sq;
  logic          disc_ok;
  logic [LW-1:0] lin;
  logic          c_we_d, c_rd_d;

  assign off_sq  = RW'(b_di_sq_q) + RW'(b_dj_sq_q);
  assign disc_ok = (kind_q != bff_pkg::KIND_DISC) || (off_sq <= r4_q);
  assign lin     = LW'(b_y_q) * LW'(eff_w) + LW'(b_x_q);
  assign c_we_d  = b_valid_q && b_in_q && disc_ok && (kind_q != bff_pkg::KIND_READ);
  assign c_rd_d  = b_valid_q && b_in_q && (kind_q == bff_pkg::KIND_READ);

  logic          c_we_q, c_rd_q, d_rd_q;
  logic [AW-1:0] c_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_we_q <= 1'b0;
      c_rd_q <= 1'b0;
      d_rd_q <= 1'b0;
    end else begin
      c_we_q <= c_we_d;
      c_rd_q <= c_rd_d;
      d_rd_q <= c_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_addr_q <= AW'(lin);
  end

  // Clear pass address
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign status_o.clr_last = (clr_q == AW'(Depth - 1));

  // Framebuffer
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bff_pkg::PixelW-1:0] ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.clr_en || c_we_q;
  assign ram_waddr = cmd_i.clr_en ? clr_q : c_addr_q;
  assign ram_wdata = cmd_i.clr_en ? '0 : pix_q;

  bff_ram #(
    .WIDTH (bff_pkg::PixelW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (c_addr_q),
    .rdata_o (ram_rdata)
  );

  // Result collection and output register
  logic [bff_pkg::PixelW-1:0]   rd_q;
  logic [bff_pkg::CountW-1:0]   count_q;
  logic [bff_pkg::OutDataW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (d_rd_q) begin
        rd_q <= ram_rdata;
      end
      if (c_we_q) begin
        count_q <= count_q + bff_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {3'b000, count_q, rd_q};
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hw/rtl/brush_fill_framebuffer_unit.sv -----
// ----------------------------------------------------------------------------
// brush_fill_framebuffer_unit
// 2D fill engine over an on-chip BGRA framebuffer with set, square, disc and
// read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one command per transfer; tuser carries the kind, tdata the
//   start corner, brush size and four Q3.12 color channels.
//   Output stream: exactly one result per command: the read pixel bytes (zero
//   unless a read) and the number of pixels written.
//   Config port: write frame width (index 0) or height (index 1) while idle.
// Timing:
//   A square or disc of side s walks all s*s offsets, one pixel per cycle
//   through a three-stage pipeline into the framebuffer write port; set and
//   read walk a single offset, a zero brush none. A new command is accepted
//   only once the previous one has walked, drained and loaded its result.
// Reset:
//   A clearing pass zeros all MAX_WIDTH * MAX_HEIGHT framebuffer words (65536
//   at default size), one word per cycle; s_axis_tready stays low until it
//   ends. Config writes are taken throughout.
// Backpressure:
//   A finished result waits in the output register; the next command is
//   accepted meanwhile, and its own result holds in the engine until the
//   output register frees up.
// ----------------------------------------------------------------------------
module brush_fill_framebuffer_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_BRUSH  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Config write port
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [bff_pkg::CfgW-1:0]         cfg_data_i,
  // Command stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: x_start[10:0], y_start[21:11], brush_side[28:22], color_red[44:29],
  //        color_green[60:45], color_blue[76:61], color_alpha[92:77], zero pad
  input  logic [bff_pkg::InDataW-1:0]      s_axis_tdata_i,
  // tuser: kind[1:0]
  input  logic [1:0]                       s_axis_tuser_i,
  // Result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16],
  //        pixel_alpha[31:24], pixels_written[44:32], zero pad
  output logic [bff_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  bff_pkg::ctrl_cmd_t  cmd;
  bff_pkg::dp_status_t status;

  // Unpack the command fields
  logic signed [bff_pkg::CoordW-1:0] x_start, y_start;
  logic [bff_pkg::BrushW-1:0]        brush_side;
  logic signed [bff_pkg::ChanW-1:0]  color_red, color_green, color_blue, color_alpha;

  assign x_start     = s_axis_tdata_i[10:0];
  assign y_start     = s_axis_tdata_i[21:11];
  assign brush_side  = s_axis_tdata_i[28:22];
  assign color_red   = s_axis_tdata_i[44:29];
  assign color_green = s_axis_tdata_i[60:45];
  assign color_blue  = s_axis_tdata_i[76:61];
  assign color_alpha = s_axis_tdata_i[92:77];

  // Sequencer: owns the handshakes, drives the datapath by command
  bff_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o)
  );

  // Datapath: pixel pipeline, framebuffer, result registers
  bff_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BRUSH  (MAX_BRUSH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (s_axis_tuser_i),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .brush_side_i  (brush_side),
    .color_red_i   (color_red),
    .color_green_i (color_green),
    .color_blue_i  (color_blue),
    .color_alpha_i (color_alpha),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_data_o    (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // No command may be taken while the framebuffer is still being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !s_axis_tready_o)
    else $error("command accepted during clear pass");

  // Never overwrite a result the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("held result overwritten");

  // Pixel issue only happens while a command is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (!s_axis_tready_o && !cmd.clr_en && !cmd.out_load))
    else $error("pixel issued outside a command");

  // A loaded result is shown on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("result loaded but not valid");
`endif

endmodule

// ----- verif/tb_brush_fill_framebuffer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brush_fill_framebuffer_unit
// Self-checking bench for the brush fill framebuffer unit. A queue-fed driver
// pushes set, square, disc and read commands through the command stream. A
// local framebuffer image tracks every write and predicts each result. A
// monitor compares each result transfer with the oldest prediction. Frame
// size registers are changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_brush_fill_framebuffer_unit;

  localparam int FbMaxW     = 256;
  localparam int FbMaxH     = 256;
  localparam int BrushMax   = 64;
  // The limit must cover the clearing pass after reset, which runs with no transfer.
  localparam int StallLimit = 300000;

  // One command as it travels on the input stream
  typedef struct packed {
    bff_pkg::kind_e     kind;
    logic signed [10:0] x_start;
    logic signed [10:0] y_start;
    logic [6:0]         brush;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic signed [15:0] alpha;
  } cmd_t;

  // One result: pixel bytes of a read and the count of written pixels
  typedef struct packed {
    logic [12:0] written;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } reply_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [0:0]                   cfg_index = bff_pkg::REG_FRAME_WIDTH;
  logic [bff_pkg::CfgW-1:0]     cfg_data = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [bff_pkg::InDataW-1:0]  s_tdata = '0;
  logic [1:0]                   s_tuser = bff_pkg::KIND_SET;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [bff_pkg::OutDataW-1:0] m_tdata;

  // Image of the framebuffer and the frame size registers as the unit holds them
  bit [31:0]   fb_image [FbMaxW*FbMaxH];
  int unsigned frame_w = 256;
  int unsigned frame_h = 256;

  cmd_t   cmd_backlog[$];
  reply_t predicted_replies[$];
  cmd_t   cmd_on_bus;
  bit     quiet_run = 1'b0;
  int     mismatch_count = 0;
  int     stall_cycles = 0;

  brush_fill_framebuffer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    // tdata: x_start, y_start, brush_side, red, green, blue, alpha, zero pad
    .s_axis_tdata_i  (s_tdata),
    // tuser: kind
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // tdata: blue, green, red, alpha, pixels_written, zero pad
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp a Q3.12 channel to 0..1 and scale to a byte, truncating
  function automatic logic [7:0] chan_level(input logic signed [15:0] v);
    int t;
    t = v;
    if (t < 0) t = 0;
    if (t > 4096) t = 4096;
    return 8'((t * 255) >>> 12);
  endfunction

  function automatic bit on_canvas(input int x, input int y, input int ew, input int eh);
    return x >= 0 && y >= 0 && x < ew && y < eh;
  endfunction

  // Apply one command to the framebuffer image and return its result
  function automatic reply_t render_command(input cmd_t c);
    reply_t      r;
    int          ew, eh, x0, y0, s, r4, di, dj, painted;
    logic [31:0] pix, rd;
    ew = (frame_w > FbMaxW) ? FbMaxW : int'(frame_w);
    eh = (frame_h > FbMaxH) ? FbMaxH : int'(frame_h);
    x0 = c.x_start;
    y0 = c.y_start;
    s  = c.brush;
    if (s > BrushMax) s = BrushMax;
    r4 = 4 * (s / 2) * (s / 2);
    pix = {chan_level(c.alpha), chan_level(c.red), chan_level(c.green), chan_level(c.blue)};
    rd = '0;
    painted = 0;
    case (c.kind)
      bff_pkg::KIND_SET: begin
        if (on_canvas(x0, y0, ew, eh)) begin
          fb_image[y0 * ew + x0] = pix;
          painted = 1;
        end
      end
      bff_pkg::KIND_READ: begin
        if (on_canvas(x0, y0, ew, eh)) rd = fb_image[y0 * ew + x0];
      end
      default: begin
        // Walk the whole brush square; the disc keeps only offsets inside the circle
        for (int i = 0; i < s; i++) begin
          di = 2 * i - s + 1;
          for (int j = 0; j < s; j++) begin
            dj = 2 * j - s + 1;
            if (on_canvas(x0 + j, y0 + i, ew, eh) &&
                !(c.kind == bff_pkg::KIND_DISC && di * di + dj * dj > r4)) begin
              fb_image[(y0 + i) * ew + x0 + j] = pix;
              painted++;
            end
          end
        end
      end
    endcase
    r.written = 13'(painted);
    r.alpha   = rd[31:24];
    r.red     = rd[23:16];
    r.green   = rd[15:8];
    r.blue    = rd[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: one transfer per handshake, random idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      // The held command is taken at this edge; fold it into the image now
      if (s_tvalid && s_tready) begin
        predicted_replies.push_back(render_command(cmd_on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() != 0 && (quiet_run || $urandom_range(0, 99) >= 6)) begin
          cmd_on_bus = cmd_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cmd_on_bus.kind;
          s_tdata  <= {3'b000, cmd_on_bus.alpha, cmd_on_bus.blue, cmd_on_bus.green,
                       cmd_on_bus.red, cmd_on_bus.brush, cmd_on_bus.y_start,
                       cmd_on_bus.x_start};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_run || $urandom_range(0, 99) >= 6;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%012h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("pixel_blue", want.blue, m_tdata[7:0]);
        check_field("pixel_green", want.green, m_tdata[15:8]);
        check_field("pixel_red", want.red, m_tdata[23:16]);
        check_field("pixel_alpha", want.alpha, m_tdata[31:24]);
        check_field("pixels_written", want.written, m_tdata[44:32]);
      end
    end
  end

  // Watchdog: too long without any transfer on either stream
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input bff_pkg::kind_e k, input int x, input int y, input int s,
                          input int r, input int g, input int b, input int a);
    cmd_t c;
    c.kind    = k;
    c.x_start = x[10:0];
    c.y_start = y[10:0];
    c.brush   = s[6:0];
    c.red     = r[15:0];
    c.green   = g[15:0];
    c.blue    = b[15:0];
    c.alpha   = a[15:0];
    cmd_backlog.push_back(c);
  endtask

  // Channel values: extremes, in-range ramp, overrange and negative
  function automatic int rand_chan();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 4096;
      2: return 4095;
      3: return int'($urandom_range(4097, 32767));
      4: return -int'($urandom_range(1, 32768));
      5: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 4096));
    endcase
  endfunction

  // Mostly close to the active frame, sometimes anywhere in the coordinate range
  function automatic int rand_coord(input int extent);
    if ($urandom_range(0, 99) < 12) return int'($urandom_range(0, 2047)) - 1024;
    return int'($urandom_range(0, extent + 40)) - 20;
  endfunction

  // Most brushes are small to keep the walk short; a few reach or pass the maximum
  function automatic int rand_brush();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 12);
    if (pick < 95) return $urandom_range(13, 32);
    return $urandom_range(33, 127);
  endfunction

  task automatic queue_directed();
    push_cmd(bff_pkg::KIND_SET, 0, 0, 0, 4096, 4096, 4096, 4096);
    push_cmd(bff_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(bff_pkg::KIND_SET, 255, 255, 127, -32768, 32767, 4095, 1);
    push_cmd(bff_pkg::KIND_READ, 255, 255, 0, 0, 0, 0, 0);
    // Off-frame set and read: nothing written, zero bytes back
    push_cmd(bff_pkg::KIND_SET, -1, 0, 0, 4096, 0, 0, 0);
    push_cmd(bff_pkg::KIND_SET, 256, 3, 0, 4096, 0, 0, 0);
    push_cmd(bff_pkg::KIND_SET, 0, -1024, 0, 4096, 0, 0, 0);
    push_cmd(bff_pkg::KIND_SET, 1023, 1023, 0, 4096, 0, 0, 0);
    push_cmd(bff_pkg::KIND_READ, -1, -1, 0, 0, 0, 0, 0);
    // Zero brush writes nothing
    push_cmd(bff_pkg::KIND_SQUARE, 5, 5, 0, 4096, 4096, 4096, 4096);
    push_cmd(bff_pkg::KIND_DISC, 6, 6, 0, 4096, 4096, 4096, 4096);
    push_cmd(bff_pkg::KIND_SQUARE, 10, 10, 1, 2048, 1000, 3000, 4096);
    push_cmd(bff_pkg::KIND_READ, 10, 10, 0, 0, 0, 0, 0);
    // Oversized brush saturates, clipped at the top-left corner
    push_cmd(bff_pkg::KIND_SQUARE, -30, -30, 127, 4097, -1, 300, 4096);
    push_cmd(bff_pkg::KIND_READ, 33, 33, 0, 0, 0, 0, 0);
    // Odd disc: edge midpoint drawn, corner left out
    push_cmd(bff_pkg::KIND_DISC, 100, 100, 7, 1234, 2345, 3456, 4000);
    push_cmd(bff_pkg::KIND_READ, 103, 100, 0, 0, 0, 0, 0);
    push_cmd(bff_pkg::KIND_READ, 100, 100, 0, 0, 0, 0, 0);
    push_cmd(bff_pkg::KIND_DISC, 200, 10, 8, 4096, 16, 32767, 0);
    push_cmd(bff_pkg::KIND_READ, 200, 14, 0, 0, 0, 0, 0);
    // Largest disc clipped at the bottom-right corner
    push_cmd(bff_pkg::KIND_DISC, 220, 220, 64, 17, 4095, 4096, 4097);
    push_cmd(bff_pkg::KIND_READ, 255, 255, 0, 0, 0, 0, 0);
    push_cmd(bff_pkg::KIND_SQUARE, 254, 254, 3, 100, 200, 300, 400);
    push_cmd(bff_pkg::KIND_DISC, 50, 50, 2, 4096, 4096, 0, 4096);
    push_cmd(bff_pkg::KIND_DISC, 60, 60, 1, 0, 4096, 4096, 4096);
  endtask

  // Draw then read back inside the brush, with some noise commands mixed in
  task automatic queue_random(input int n);
    int made, ew, eh, x, y, s, reads;
    bff_pkg::kind_e k;
    made = 0;
    ew = (frame_w > FbMaxW) ? FbMaxW : int'(frame_w);
    eh = (frame_h > FbMaxH) ? FbMaxH : int'(frame_h);
    while (made < n) begin
      if ($urandom_range(0, 99) < 10) begin
        k = bff_pkg::kind_e'($urandom_range(0, 3));
        push_cmd(k, int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                 (k == bff_pkg::KIND_SET || k == bff_pkg::KIND_READ)
                   ? int'($urandom_range(0, 127)) : int'($urandom_range(0, 15)),
                 rand_chan(), rand_chan(), rand_chan(), rand_chan());
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: k = bff_pkg::KIND_SET;
          3, 4, 5: k = bff_pkg::KIND_SQUARE;
          default: k = bff_pkg::KIND_DISC;
        endcase
        x = rand_coord(ew);
        y = rand_coord(eh);
        s = (k == bff_pkg::KIND_SET) ? 1 : rand_brush();
        push_cmd(k, x, y, (k == bff_pkg::KIND_SET) ? int'($urandom_range(0, 127)) : s,
                 rand_chan(), rand_chan(), rand_chan(), rand_chan());
        if (s > BrushMax) s = BrushMax;
        if (s < 1) s = 1;
        reads = $urandom_range(0, 3);
        for (int i = 0; i < reads; i++) begin
          push_cmd(bff_pkg::KIND_READ, x + int'($urandom_range(0, s - 1)),
                   y + int'($urandom_range(0, s - 1)), int'($urandom_range(0, 127)),
                   rand_chan(), rand_chan(), rand_chan(), rand_chan());
        end
      end
      made++;
    end
  endtask

  // Hold until every command is taken and every result has come back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (bff_pkg::DrainCycles + 2) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= bff_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w[8:0];
    @(posedge clk_i);
    cfg_index <= bff_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h[8:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    frame_w = w[8:0];
    frame_h = h[8:0];
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int w, input int h, input int n, input bit calm);
    wait_idle();
    set_frame(w, h);
    quiet_run = calm;
    queue_random(n);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Default frame first; commands wait out the clearing pass
    set_frame(256, 256);
    queue_directed();
    queue_random(40);
    run_phase(20, 13, 40, 1'b1);   // small frame, no idling on either side
    run_phase(0, 37, 12, 1'b0);    // zero width clips everything
    run_phase(37, 0, 12, 1'b0);    // zero height clips everything
    run_phase(511, 511, 40, 1'b0); // both registers saturate
    run_phase(1, 256, 30, 1'b0);
    run_phase(256, 1, 30, 1'b0);
    run_phase(300, 5, 25, 1'b0);
    for (int p = 0; p < 3; p++) begin
      run_phase($urandom_range(1, 256), $urandom_range(1, 256), 22, 1'b0);
    end
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
